FILE: rtl/core/psc_pkg.sv
// psc_pkg: shared types, constants and register indexes for the pilot state classifier
// depends on nothing; used by every module in rtl/core
`timescale 1ns / 1ps
`default_nettype none

package psc_pkg;

    // design constants
    localparam int SAMPLE_BITS    = 12;
    localparam int STABLE_REPEATS = 3;
    localparam int SAMPLE_W       = 12;
    localparam int WIN_W          = 13;
    localparam int REPEAT_W       = $clog2(STABLE_REPEATS + 1);
    localparam int CFG_INDEX_W    = 4;
    localparam int CFG_DATA_W     = 17;
    localparam int FRAC_BITS      = 10;
    localparam int DIFF_W         = 14;
    localparam int PROD_W         = 31;
    localparam int NUM_W          = 33;

    localparam logic [WIN_W-1:0]    TROUGH_RESET = WIN_W'(5000);
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK  = SAMPLE_W'((1 << SAMPLE_BITS) - 1);

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_THR_NC    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_THR_CONN  = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_THR_READY = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_THR_VENT  = CFG_INDEX_W'(3);
    localparam logic [CFG_INDEX_W-1:0] REG_THR_NEG   = CFG_INDEX_W'(4);
    localparam logic [CFG_INDEX_W-1:0] REG_CAL_PILOT = CFG_INDEX_W'(5);
    localparam logic [CFG_INDEX_W-1:0] REG_CAL_ADC   = CFG_INDEX_W'(6);
    localparam logic [CFG_INDEX_W-1:0] REG_CAL_SLOPE = CFG_INDEX_W'(7);

    // pilot states as reported on the result channel
    typedef enum logic [2:0] {
        STATE_A = 3'd0,
        STATE_B = 3'd1,
        STATE_C = 3'd2,
        STATE_D = 3'd3,
        STATE_E = 3'd4,
        STATE_F = 3'd5
    } pilot_state_t;

    // input item
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_mv;
        logic                last_in_window;
        logic                pwm_active;
    } sample_t;

    // result item
    typedef struct packed {
        logic [2:0]         vehicle_state;
        logic signed [15:0] pilot_high_mv;
        logic signed [15:0] pilot_low_mv;
    } result_t;

    // configuration register file
    typedef struct packed {
        logic signed [15:0] thresh_not_connected_mv;
        logic signed [15:0] thresh_connected_mv;
        logic signed [15:0] thresh_ready_mv;
        logic signed [15:0] thresh_ventilation_mv;
        logic signed [15:0] thresh_negative_mv;
        logic signed [15:0] cal_pilot_base_mv;
        logic [11:0]        cal_adc_base_mv;
        logic signed [16:0] cal_slope_q10;
    } cfg_t;

    // closed window extremes in adc millivolts
    typedef struct packed {
        logic [WIN_W-1:0] peak;
        logic [WIN_W-1:0] trough;
        logic             pwm;
    } window_t;

    // calibrated window extremes in pilot millivolts
    typedef struct packed {
        logic signed [15:0] high_mv;
        logic signed [15:0] low_mv;
        logic               pwm;
    } pilot_mv_t;

endpackage

`default_nettype wire

FILE: rtl/core/psc_window.sv
// psc_window: running peak and trough of the sampling window, closed on the last sample
// depends on psc_pkg
`timescale 1ns / 1ps
`default_nettype none

module psc_window
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              sample_valid,
    output logic                   sample_stall,
    input  wire psc_pkg::sample_t  sample,
    output logic                   win_valid,
    input  wire logic              win_stall,
    output psc_pkg::window_t       win
);

    logic [psc_pkg::WIN_W-1:0] peak_reg;
    logic [psc_pkg::WIN_W-1:0] trough_reg;
    logic [psc_pkg::WIN_W-1:0] peak_next;
    logic [psc_pkg::WIN_W-1:0] trough_next;
    logic [psc_pkg::WIN_W-1:0] x;
    logic                      win_valid_reg;
    psc_pkg::window_t          win_reg;
    logic                      accept;

    // handshake: hold off while a closed window waits downstream
    assign sample_stall = win_valid_reg && win_stall;
    assign accept       = sample_valid && !sample_stall;

    // fold the sample into the window extremes
    assign x           = psc_pkg::WIN_W'(sample.sample_mv & psc_pkg::SAMPLE_MASK);
    assign peak_next   = (x > peak_reg)   ? x : peak_reg;
    assign trough_next = (x < trough_reg) ? x : trough_reg;

    // window extremes, cleared when the window closes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg   <= '0;
            trough_reg <= psc_pkg::TROUGH_RESET;
        end
        else if (accept)
        begin
            if (sample.last_in_window)
            begin
                peak_reg   <= '0;
                trough_reg <= psc_pkg::TROUGH_RESET;
            end
            else
            begin
                peak_reg   <= peak_next;
                trough_reg <= trough_next;
            end
        end
    end

    // closed window register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_valid_reg <= 1'b0;
        end
        else if (!sample_stall)
        begin
            win_valid_reg <= accept && sample.last_in_window;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && sample.last_in_window)
        begin
            win_reg.peak   <= peak_next;
            win_reg.trough <= trough_next;
            win_reg.pwm    <= sample.pwm_active;
        end
    end

    assign win_valid = win_valid_reg;
    assign win       = win_reg;

    // a closing transfer leaves an empty window behind
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sample.last_in_window) |=>
            (peak_reg == '0 && trough_reg == psc_pkg::TROUGH_RESET))
        else $error("window not cleared after closing sample");

    // a reported window always has its trough at or below its peak
    assert property (@(posedge clk) disable iff (!rst_n)
        win_valid_reg |-> (win_reg.trough <= win_reg.peak))
        else $error("closed window trough above peak");

endmodule

`default_nettype wire

FILE: rtl/core/psc_calib.sv
// psc_calib: linear calibration of peak and trough to pilot millivolts, two stages
// depends on psc_pkg
`timescale 1ns / 1ps
`default_nettype none

module psc_calib
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire psc_pkg::cfg_t     cfg,
    input  wire logic              win_valid,
    output logic                   win_stall,
    input  wire psc_pkg::window_t  win,
    output logic                   mv_valid,
    input  wire logic              mv_stall,
    output psc_pkg::pilot_mv_t     mv
);

    // truncate toward zero after the fraction shift, then saturate to 16 bits
    function automatic logic signed [15:0] trunc_sat(input logic signed [psc_pkg::NUM_W-1:0] num);
        logic signed [psc_pkg::NUM_W-1:0] q;
        q = num >>> psc_pkg::FRAC_BITS;
        if (num[psc_pkg::NUM_W-1] && (|num[psc_pkg::FRAC_BITS-1:0]))
        begin
            q = q + psc_pkg::NUM_W'(1);
        end
        if (q > $signed(psc_pkg::NUM_W'(32767)))
        begin
            trunc_sat = 16'sh7FFF;
        end
        else if (q < -$signed(psc_pkg::NUM_W'(32768)))
        begin
            trunc_sat = -16'sh8000;
        end
        else
        begin
            trunc_sat = q[15:0];
        end
    endfunction

    logic signed [psc_pkg::DIFF_W-1:0] diff_hi;
    logic signed [psc_pkg::DIFF_W-1:0] diff_lo;
    logic signed [psc_pkg::PROD_W-1:0] prod_hi_next;
    logic signed [psc_pkg::PROD_W-1:0] prod_lo_next;
    logic signed [psc_pkg::PROD_W-1:0] prod_hi_reg;
    logic signed [psc_pkg::PROD_W-1:0] prod_lo_reg;
    logic                              pwm_reg;
    logic                              prod_valid_reg;
    logic                              prod_stall;
    logic signed [psc_pkg::NUM_W-1:0]  base_q;
    logic signed [psc_pkg::NUM_W-1:0]  num_hi;
    logic signed [psc_pkg::NUM_W-1:0]  num_lo;
    logic                              mv_valid_reg;
    psc_pkg::pilot_mv_t                mv_reg;

    // stage 1: offset from the reference reading times slope
    assign diff_hi = $signed({1'b0, win.peak})
                   - $signed({2'b00, cfg.cal_adc_base_mv});
    assign diff_lo = $signed({1'b0, win.trough})
                   - $signed({2'b00, cfg.cal_adc_base_mv});
    assign prod_hi_next = diff_hi * $signed(cfg.cal_slope_q10);
    assign prod_lo_next = diff_lo * $signed(cfg.cal_slope_q10);

    assign win_stall = prod_valid_reg && prod_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else if (!win_stall)
        begin
            prod_valid_reg <= win_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_valid && !win_stall)
        begin
            prod_hi_reg <= prod_hi_next;
            prod_lo_reg <= prod_lo_next;
            pwm_reg     <= win.pwm;
        end
    end

    // stage 2: add the base, shift out the fraction, saturate
    assign base_q = $signed(psc_pkg::NUM_W'($signed(cfg.cal_pilot_base_mv)))
                    <<< psc_pkg::FRAC_BITS;
    assign num_hi = base_q + $signed(psc_pkg::NUM_W'(prod_hi_reg));
    assign num_lo = base_q + $signed(psc_pkg::NUM_W'(prod_lo_reg));

    assign prod_stall = mv_valid_reg && mv_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_valid_reg <= 1'b0;
        end
        else if (!prod_stall)
        begin
            mv_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_valid_reg && !prod_stall)
        begin
            mv_reg.high_mv <= trunc_sat(num_hi);
            mv_reg.low_mv  <= trunc_sat(num_lo);
            mv_reg.pwm     <= pwm_reg;
        end
    end

    assign mv_valid = mv_valid_reg;
    assign mv       = mv_reg;

    // a window in stage 1 passes to stage 2 in the next cycle unless held
    assert property (@(posedge clk) disable iff (!rst_n)
        (prod_valid_reg && !prod_stall) |=> mv_valid_reg)
        else $error("calibration stage dropped a window");

endmodule

`default_nettype wire

FILE: rtl/core/psc_classify.sv
// psc_classify: threshold classification, missing diode check, debounce and result register
// depends on psc_pkg
`timescale 1ns / 1ps
`default_nettype none

module psc_classify
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire psc_pkg::cfg_t      cfg,
    input  wire logic               mv_valid,
    output logic                    mv_stall,
    input  wire psc_pkg::pilot_mv_t mv,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output psc_pkg::result_t        result
);

    psc_pkg::pilot_state_t        raw_state;
    psc_pkg::pilot_state_t        st;
    psc_pkg::pilot_state_t        cand_reg;
    psc_pkg::pilot_state_t        cand_next;
    psc_pkg::pilot_state_t        commit_reg;
    psc_pkg::pilot_state_t        commit_next;
    logic [psc_pkg::REPEAT_W-1:0] count_reg;
    logic [psc_pkg::REPEAT_W-1:0] count_next;
    logic                         result_valid_reg;
    psc_pkg::result_t             result_reg;
    logic                         load;

    assign mv_stall = result_valid_reg && result_stall;
    assign load     = mv_valid && !mv_stall;

    // peak against the descending thresholds
    always_comb
    begin
        if (mv.high_mv >= $signed(cfg.thresh_not_connected_mv))
        begin
            raw_state = psc_pkg::STATE_A;
        end
        else if (mv.high_mv >= $signed(cfg.thresh_connected_mv))
        begin
            raw_state = psc_pkg::STATE_B;
        end
        else if (mv.high_mv >= $signed(cfg.thresh_ready_mv))
        begin
            raw_state = psc_pkg::STATE_C;
        end
        else if (mv.high_mv >= $signed(cfg.thresh_ventilation_mv))
        begin
            raw_state = psc_pkg::STATE_D;
        end
        else
        begin
            raw_state = psc_pkg::STATE_E;
        end
    end

    // missing diode: trough never reaches the negative level while pwm runs, outside state A
    assign st = (mv.pwm && raw_state != psc_pkg::STATE_A
                 && mv.low_mv > $signed(cfg.thresh_negative_mv))
                ? psc_pkg::STATE_F : raw_state;

    // debounce
    always_comb
    begin
        if (st == cand_reg)
        begin
            cand_next  = cand_reg;
            count_next = (count_reg < psc_pkg::REPEAT_W'(psc_pkg::STABLE_REPEATS))
                         ? count_reg + psc_pkg::REPEAT_W'(1) : count_reg;
        end
        else
        begin
            cand_next  = st;
            count_next = '0;
        end
        commit_next = (count_next >= psc_pkg::REPEAT_W'(psc_pkg::STABLE_REPEATS))
                      ? cand_next : commit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg   <= psc_pkg::STATE_F;
            count_reg  <= '0;
            commit_reg <= psc_pkg::STATE_A;
        end
        else if (load)
        begin
            cand_reg   <= cand_next;
            count_reg  <= count_next;
            commit_reg <= commit_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (!mv_stall)
        begin
            result_valid_reg <= mv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg.vehicle_state <= commit_next;
            result_reg.pilot_high_mv <= mv.high_mv;
            result_reg.pilot_low_mv  <= mv.low_mv;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // the committed state only moves once the candidate has repeated enough
    assert property (@(posedge clk) disable iff (!rst_n)
        (commit_reg != $past(commit_reg)) |->
            (count_reg == psc_pkg::REPEAT_W'(psc_pkg::STABLE_REPEATS)
             && commit_reg == cand_reg))
        else $error("state committed before debounce completed");

    // debounce state only changes on a window transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        !load |=> ($stable(cand_reg) && $stable(count_reg) && $stable(commit_reg)))
        else $error("debounce state moved without a window");

    // a reported state matches the committed state
    assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (result_reg.vehicle_state == commit_reg))
        else $error("result state differs from committed state");

endmodule

`default_nettype wire

FILE: rtl/core/pilot_state_classifier_top.sv
// pilot_state_classifier_top: control pilot state detection, top level with register file
// depends on psc_pkg, psc_window, psc_calib, psc_classify
//
// Usage:
//   sample channel (sample_valid / sample_stall / sample): one adc reading per transfer,
//   with last_in_window marking the final sample of a window and pwm_active its pwm flag.
//   result channel (result_valid / result_stall / result): one transfer per closed window,
//   carrying the debounced state and the calibrated peak and trough in millivolts.
//   Throughput is one sample per cycle while sample_stall is low; the running peak/trough
//   compare is the only per-sample loop. The closing sample transfer loads the window
//   register; the window then passes through the slope multiply register, the base add
//   with truncation and saturation into the mv register, and classify into the result
//   register, which drives result_valid.
//   Each stage holds its item while the next is full, so a stall on the result side
//   backs up stage by stage and reaches sample_stall only once a closed window is waiting.
//   Reset empties the window, sets the candidate to F, the committed state to A, loads
//   the default thresholds and calibration and clears all valid flags.
//   cfg_we writes cfg_wdata to register cfg_index; indexes above 7 are ignored.
`timescale 1ns / 1ps
`default_nettype none

module pilot_state_classifier_top
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              sample_valid,
    output logic                                   sample_stall,
    input  wire psc_pkg::sample_t                  sample,
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output psc_pkg::result_t                       result,
    input  wire logic                              cfg_we,
    input  wire logic [psc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [psc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    psc_pkg::cfg_t      cfg_reg;
    logic               win_valid;
    logic               win_stall;
    psc_pkg::window_t   win;
    logic               mv_valid;
    logic               mv_stall;
    psc_pkg::pilot_mv_t mv;

    // configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.thresh_not_connected_mv <= 16'sd10500;
            cfg_reg.thresh_connected_mv     <= 16'sd7500;
            cfg_reg.thresh_ready_mv         <= 16'sd4500;
            cfg_reg.thresh_ventilation_mv   <= 16'sd1500;
            cfg_reg.thresh_negative_mv      <= -16'sd10000;
            cfg_reg.cal_pilot_base_mv       <= -16'sd12000;
            cfg_reg.cal_adc_base_mv         <= 12'd300;
            cfg_reg.cal_slope_q10           <= 17'sd8777;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                psc_pkg::REG_THR_NC:    cfg_reg.thresh_not_connected_mv <= cfg_wdata[15:0];
                psc_pkg::REG_THR_CONN:  cfg_reg.thresh_connected_mv     <= cfg_wdata[15:0];
                psc_pkg::REG_THR_READY: cfg_reg.thresh_ready_mv         <= cfg_wdata[15:0];
                psc_pkg::REG_THR_VENT:  cfg_reg.thresh_ventilation_mv   <= cfg_wdata[15:0];
                psc_pkg::REG_THR_NEG:   cfg_reg.thresh_negative_mv      <= cfg_wdata[15:0];
                psc_pkg::REG_CAL_PILOT: cfg_reg.cal_pilot_base_mv       <= cfg_wdata[15:0];
                psc_pkg::REG_CAL_ADC:   cfg_reg.cal_adc_base_mv         <= cfg_wdata[11:0];
                psc_pkg::REG_CAL_SLOPE: cfg_reg.cal_slope_q10           <= cfg_wdata[16:0];
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // window tracking
    psc_window u_window
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .win_valid    (win_valid),
        .win_stall    (win_stall),
        .win          (win)
    );

    // calibration to pilot millivolts
    psc_calib u_calib
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .win_valid (win_valid),
        .win_stall (win_stall),
        .win       (win),
        .mv_valid  (mv_valid),
        .mv_stall  (mv_stall),
        .mv        (mv)
    );

    // classification, debounce and result register
    psc_classify u_classify
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .mv_valid     (mv_valid),
        .mv_stall     (mv_stall),
        .mv           (mv),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

FILE: tb/sv/pilot_state_classifier_top_tb.sv
// pilot_state_classifier_top_tb: self-checking bench for the pilot state classifier top level
// depends on psc_pkg and pilot_state_classifier_top; predicts each window result in-bench
`timescale 1ns / 1ps

module pilot_state_classifier_top_tb;

    localparam int CYCLE_LIMIT     = 300000;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 12;
    localparam int PHASE_COUNT     = 8;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int ADC_MAX         = (1 << psc_pkg::SAMPLE_W) - 1;
    localparam longint CAL_SCALE   = longint'(1) << psc_pkg::FRAC_BITS;
    localparam longint MV_MAX      = 32767;
    localparam longint MV_MIN      = -32768;

    typedef enum {
        CFG_RESET_VALUES,
        CFG_ORDERED,
        CFG_ALL_LOW,
        CFG_ALL_HIGH,
        CFG_SCRAMBLED
    } cfg_kind_t;

    typedef enum {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    // dut ports
    logic                            clk          = 1'b0;
    logic                            rst_n        = 1'b0;
    logic                            sample_valid = 1'b0;
    logic                            sample_stall;
    psc_pkg::sample_t                sample       = '0;
    logic                            result_valid;
    logic                            result_stall = 1'b0;
    psc_pkg::result_t                result;
    logic                            cfg_we       = 1'b0;
    logic [psc_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [psc_pkg::CFG_DATA_W-1:0]  cfg_wdata    = '0;

    // bench state
    psc_pkg::sample_t pending_samples[$];
    psc_pkg::result_t expected_results[$];
    int           mismatch_count = 0;
    int           cycles_run     = 0;
    int           burst_left     = 0;
    int           gap_left       = 0;
    int           hold_requests  = 0;
    int           holds_served   = 0;
    int           hold_left      = 0;
    int           pattern_left   = 0;
    stall_mode_t  stall_mode     = STALL_NONE;
    logic         took;

    // predictor copy of registers and window/debounce state
    psc_pkg::cfg_t             model_cfg;
    logic [psc_pkg::WIN_W-1:0] win_peak;
    logic [psc_pkg::WIN_W-1:0] win_trough;
    psc_pkg::pilot_state_t     cand_state;
    int                        cand_repeats;
    psc_pkg::pilot_state_t     held_state;

    pilot_state_classifier_top dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // linear adc to pilot conversion, truncated toward zero and saturated
    function automatic logic signed [15:0] to_pilot_mv(logic [psc_pkg::WIN_W-1:0] adc);
        longint acc;
        longint v;
        acc = longint'(model_cfg.cal_pilot_base_mv) * CAL_SCALE
            + (longint'(adc) - longint'(model_cfg.cal_adc_base_mv))
              * longint'(model_cfg.cal_slope_q10);
        v = acc / CAL_SCALE;
        if (v > MV_MAX)
            v = MV_MAX;
        if (v < MV_MIN)
            v = MV_MIN;
        return 16'(v);
    endfunction

    // fold one accepted sample into the window; on the closing sample queue the result
    task automatic predict_window_sample(psc_pkg::sample_t s);
        logic [psc_pkg::WIN_W-1:0] x;
        logic signed [15:0]        hi;
        logic signed [15:0]        lo;
        psc_pkg::pilot_state_t     st;
        psc_pkg::result_t          r;
        x = psc_pkg::WIN_W'(s.sample_mv & psc_pkg::SAMPLE_MASK);
        if (x > win_peak)
            win_peak = x;
        if (x < win_trough)
            win_trough = x;
        if (!s.last_in_window)
            return;
        hi = to_pilot_mv(win_peak);
        lo = to_pilot_mv(win_trough);
        if (hi >= model_cfg.thresh_not_connected_mv)
            st = psc_pkg::STATE_A;
        else if (hi >= model_cfg.thresh_connected_mv)
            st = psc_pkg::STATE_B;
        else if (hi >= model_cfg.thresh_ready_mv)
            st = psc_pkg::STATE_C;
        else if (hi >= model_cfg.thresh_ventilation_mv)
            st = psc_pkg::STATE_D;
        else
            st = psc_pkg::STATE_E;
        // missing diode: pwm running, not state A, trough never went negative enough
        if (s.pwm_active && st != psc_pkg::STATE_A && lo > model_cfg.thresh_negative_mv)
            st = psc_pkg::STATE_F;
        // debounce
        if (st == cand_state)
        begin
            if (cand_repeats < psc_pkg::STABLE_REPEATS)
                cand_repeats++;
        end
        else
        begin
            cand_state   = st;
            cand_repeats = 0;
        end
        if (cand_repeats >= psc_pkg::STABLE_REPEATS)
            held_state = cand_state;
        r.vehicle_state = held_state;
        r.pilot_high_mv = hi;
        r.pilot_low_mv  = lo;
        expected_results.push_back(r);
        win_peak   = '0;
        win_trough = psc_pkg::TROUGH_RESET;
    endtask

    // sample driver: bursts with random gaps, fed from pending_samples
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample       <= '0;
        end
        else
        begin
            took = sample_valid && !sample_stall;
            if (took)
                predict_window_sample(sample);
            if (!sample_valid || took)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    sample_valid <= 1'b0;
                end
                else if (pending_samples.size() != 0)
                begin
                    sample       <= pending_samples.pop_front();
                    sample_valid <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        if ($urandom_range(0, 7) == 0)
                            burst_left = $urandom_range(50, 200);
                        else
                            burst_left = $urandom_range(1, 24);
                        if ($urandom_range(0, 3) == 0)
                            gap_left = 0;
                        else
                            gap_left = $urandom_range(1, 12);
                    end
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    // result stall pattern, with long hold-offs on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                stall_mode   = stall_mode_t'($urandom_range(0, 3));
                pattern_left = $urandom_range(16, 128);
            end
            else
                pattern_left--;
            case (stall_mode)
                STALL_NONE:     result_stall <= 1'b0;
                STALL_LIGHT:    result_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:    result_stall <= ($urandom_range(0, 3) != 0);
                default:        result_stall <= pattern_left[2];
            endcase
        end
    end

    // result monitor: compare each transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %p", $time, result);
                mismatch_count++;
            end
            else
            begin
                psc_pkg::result_t want;
                want = expected_results.pop_front();
                if (result.vehicle_state !== want.vehicle_state)
                begin
                    $display("%0t: vehicle_state expected %0d actual %0d",
                             $time, want.vehicle_state, result.vehicle_state);
                    mismatch_count++;
                end
                if (result.pilot_high_mv !== want.pilot_high_mv)
                begin
                    $display("%0t: pilot_high_mv expected %0d actual %0d",
                             $time, want.pilot_high_mv, result.pilot_high_mv);
                    mismatch_count++;
                end
                if (result.pilot_low_mv !== want.pilot_low_mv)
                begin
                    $display("%0t: pilot_low_mv expected %0d actual %0d",
                             $time, want.pilot_low_mv, result.pilot_low_mv);
                    mismatch_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles_run++;
        if (cycles_run >= CYCLE_LIMIT)
        begin
            $display("pilot_state_classifier_top_tb: done, errors");
            $finish;
        end
    end

    task automatic add_item(int mv, bit last, bit pwm);
        psc_pkg::sample_t s;
        s.sample_mv      = psc_pkg::SAMPLE_W'(mv);
        s.last_in_window = last;
        s.pwm_active     = pwm;
        pending_samples.push_back(s);
    endtask

    // one register write transfer; the predictor copy follows at once since the block is idle
    task automatic write_reg(logic [psc_pkg::CFG_INDEX_W-1:0] idx,
                             logic [psc_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            psc_pkg::REG_THR_NC:    model_cfg.thresh_not_connected_mv = data[15:0];
            psc_pkg::REG_THR_CONN:  model_cfg.thresh_connected_mv     = data[15:0];
            psc_pkg::REG_THR_READY: model_cfg.thresh_ready_mv         = data[15:0];
            psc_pkg::REG_THR_VENT:  model_cfg.thresh_ventilation_mv   = data[15:0];
            psc_pkg::REG_THR_NEG:   model_cfg.thresh_negative_mv      = data[15:0];
            psc_pkg::REG_CAL_PILOT: model_cfg.cal_pilot_base_mv       = data[15:0];
            psc_pkg::REG_CAL_ADC:   model_cfg.cal_adc_base_mv         = data[11:0];
            psc_pkg::REG_CAL_SLOPE: model_cfg.cal_slope_q10           = data[16:0];
            default:       ;
        endcase
    endtask

    // random bits above the register width, which the block must drop
    function automatic logic [psc_pkg::CFG_DATA_W-1:0] pad_junk(int v, int width);
        logic [psc_pkg::CFG_DATA_W-1:0] m;
        m = psc_pkg::CFG_DATA_W'((1 << width) - 1);
        return (psc_pkg::CFG_DATA_W'(v) & m) | (psc_pkg::CFG_DATA_W'($urandom) & ~m);
    endfunction

    task automatic load_config(cfg_kind_t kind);
        int t_nc;
        int t_conn;
        int t_ready;
        int t_vent;
        int t_neg;
        int p_base;
        int a_base;
        int slope_v;
        case (kind)
            CFG_RESET_VALUES:
            begin
                t_nc = 10500; t_conn = 7500; t_ready = 4500; t_vent = 1500;
                t_neg = -10000; p_base = -12000; a_base = 300; slope_v = 8777;
            end
            CFG_ORDERED:
            begin
                t_vent  = -8000 + int'($urandom_range(0, 8000));
                t_ready = t_vent + int'($urandom_range(0, 8000));
                t_conn  = t_ready + int'($urandom_range(0, 8000));
                t_nc    = t_conn + int'($urandom_range(0, 8000));
                t_neg   = -14000 + int'($urandom_range(0, 8000));
                p_base  = -15000 + int'($urandom_range(0, 6000));
                a_base  = $urandom_range(0, 600);
                slope_v = $urandom_range(7000, 10000);
            end
            CFG_ALL_LOW:
            begin
                t_nc = -32768; t_conn = -32768; t_ready = -32768; t_vent = -32768;
                t_neg = -32768; p_base = -32768; a_base = 0; slope_v = -65536;
            end
            CFG_ALL_HIGH:
            begin
                t_nc = 32767; t_conn = 32767; t_ready = 32767; t_vent = 32767;
                t_neg = 32767; p_base = 32767; a_base = ADC_MAX; slope_v = 65535;
            end
            default:
            begin
                t_nc    = int'($urandom_range(0, 65535)) - 32768;
                t_conn  = int'($urandom_range(0, 65535)) - 32768;
                t_ready = int'($urandom_range(0, 65535)) - 32768;
                t_vent  = int'($urandom_range(0, 65535)) - 32768;
                t_neg   = int'($urandom_range(0, 65535)) - 32768;
                p_base  = int'($urandom_range(0, 65535)) - 32768;
                a_base  = $urandom_range(0, ADC_MAX);
                slope_v = int'($urandom_range(0, 131071)) - 65536;
            end
        endcase
        write_reg(psc_pkg::REG_THR_NC,    pad_junk(t_nc, 16));
        write_reg(psc_pkg::REG_THR_CONN,  pad_junk(t_conn, 16));
        write_reg(psc_pkg::REG_THR_READY, pad_junk(t_ready, 16));
        write_reg(psc_pkg::REG_THR_VENT,  pad_junk(t_vent, 16));
        write_reg(psc_pkg::REG_THR_NEG,   pad_junk(t_neg, 16));
        write_reg(psc_pkg::REG_CAL_PILOT, pad_junk(p_base, 16));
        write_reg(psc_pkg::REG_CAL_ADC,   pad_junk(a_base, 12));
        write_reg(psc_pkg::REG_CAL_SLOPE, pad_junk(slope_v, 17));
        // an index past the register file must change nothing
        write_reg(psc_pkg::CFG_INDEX_W'($urandom_range(int'(psc_pkg::REG_CAL_SLOPE) + 1,
                                                       (1 << psc_pkg::CFG_INDEX_W) - 1)),
                  psc_pkg::CFG_DATA_W'($urandom));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // mostly runs of windows around one level so the debouncer commits, plus noise
    task automatic queue_random_items(int count);
        int added;
        int level;
        int spread;
        int n_win;
        int len;
        int v;
        bit pwm;
        added = 0;
        while (added < count)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                add_item($urandom_range(0, ADC_MAX), 1'($urandom), 1'($urandom));
                added++;
            end
            else
            begin
                level  = $urandom_range(0, ADC_MAX);
                spread = $urandom_range(0, 64);
                pwm    = 1'($urandom);
                n_win  = $urandom_range(1, 8);
                for (int w = 0; w < n_win; w++)
                begin
                    len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 6);
                    if ($urandom_range(0, 15) == 0)
                        pwm = !pwm;
                    for (int k = 0; k < len; k++)
                    begin
                        v = level + int'($urandom_range(0, 2 * spread)) - spread;
                        if (v < 0)
                            v = 0;
                        if (v > ADC_MAX)
                            v = ADC_MAX;
                        add_item(v, k == len - 1, pwm);
                        added++;
                    end
                end
            end
        end
    endtask

    // sender pause until every expected result has arrived, then let the pipe settle
    task automatic wait_drained();
        while (pending_samples.size() != 0 || sample_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // stimulus sequence
    initial
    begin
        int        levels[6];
        cfg_kind_t phase_kinds[PHASE_COUNT];
        model_cfg.thresh_not_connected_mv = 16'sd10500;
        model_cfg.thresh_connected_mv     = 16'sd7500;
        model_cfg.thresh_ready_mv         = 16'sd4500;
        model_cfg.thresh_ventilation_mv   = 16'sd1500;
        model_cfg.thresh_negative_mv      = -16'sd10000;
        model_cfg.cal_pilot_base_mv       = -16'sd12000;
        model_cfg.cal_adc_base_mv         = 12'd300;
        model_cfg.cal_slope_q10           = 17'sd8777;
        win_peak     = '0;
        win_trough   = psc_pkg::TROUGH_RESET;
        cand_state   = psc_pkg::STATE_F;
        cand_repeats = 0;
        held_state   = psc_pkg::STATE_A;
        phase_kinds  = '{CFG_ORDERED, CFG_ALL_LOW, CFG_ALL_HIGH, CFG_ORDERED,
                         CFG_SCRAMBLED, CFG_RESET_VALUES, CFG_ORDERED, CFG_SCRAMBLED};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // one-sample windows at levels for A through E, then F with pwm, four each
        levels = '{ADC_MAX, 2600, 2300, 1900, 0, 1900};
        @(negedge clk);
        for (int k = 0; k < 6; k++)
            for (int r = 0; r < 4; r++)
                add_item(levels[k], 1'b1, k == 5);
        // one window spanning both sample extremes with pwm
        add_item(0, 1'b0, 1'b1);
        add_item(ADC_MAX, 1'b0, 1'b1);
        add_item(2000, 1'b1, 1'b1);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            wait_drained();
            load_config(phase_kinds[p]);
            @(negedge clk);
            queue_random_items(ITEMS_PER_PHASE);
            // long receiver hold-off while samples keep coming
            if (p % 3 == 1)
                hold_requests++;
        end
        wait_drained();

        if (mismatch_count == 0)
            $display("pilot_state_classifier_top_tb: done, clean");
        else
            $display("pilot_state_classifier_top_tb: done, errors");
        $finish;
    end

endmodule
